// File: hw/rtl/ggc_pkg.sv
// Package for the go-to-goal controller: widths, CORDIC constants, config indexes.
// No dependencies.
`default_nettype none
package ggc_pkg;
    localparam int CordicSteps = 16;
    localparam int Guard       = 24;
    localparam int Cw          = 64;                 // CORDIC datapath width
    localparam int StepW       = $clog2(CordicSteps + 1);
    localparam logic signed [Cw-1:0] PiQ30 = 64'sd3373259426;
    localparam logic [27:0] InvKQ28 = 28'd163008219;

    localparam logic [1:0] CfgGoalX  = 2'd0;
    localparam logic [1:0] CfgGoalY  = 2'd1;
    localparam logic [1:0] CfgGainLn = 2'd2;
    localparam logic [1:0] CfgGainAn = 2'd3;

    typedef struct packed {
        logic signed [Cw-1:0] x;
        logic signed [Cw-1:0] y;
        logic signed [Cw-1:0] z;
    } t_cvec;

    function automatic logic signed [Cw-1:0] atan_q30(input logic [4:0] i);
        logic signed [Cw-1:0] r;
        case (i)
            5'd0:  r = 64'sd843314856;
            5'd1:  r = 64'sd497837829;
            5'd2:  r = 64'sd263043836;
            5'd3:  r = 64'sd133525158;
            5'd4:  r = 64'sd67021686;
            5'd5:  r = 64'sd33543515;
            5'd6:  r = 64'sd16775850;
            5'd7:  r = 64'sd8388437;
            5'd8:  r = 64'sd4194282;
            5'd9:  r = 64'sd2097149;
            5'd10: r = 64'sd1048575;
            5'd11: r = 64'sd524287;
            5'd12: r = 64'sd262143;
            5'd13: r = 64'sd131071;
            5'd14: r = 64'sd65535;
            5'd15: r = 64'sd32767;
            5'd16: r = 64'sd16383;
            5'd17: r = 64'sd8191;
            5'd18: r = 64'sd4095;
            5'd19: r = 64'sd2047;
            5'd20: r = 64'sd1023;
            5'd21: r = 64'sd511;
            5'd22: r = 64'sd255;
            5'd23: r = 64'sd127;
            5'd24: r = 64'sd63;
            5'd25: r = 64'sd31;
            5'd26: r = 64'sd15;
            5'd27: r = 64'sd7;
            5'd28: r = 64'sd3;
            5'd29: r = 64'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/ggc_pose_if.sv
// Valid/ready channel carrying one odometry pose.
// No dependencies.
`default_nettype none
interface ggc_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    modport source (output valid, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ggc_cmd_if.sv
// Valid/ready channel carrying one speed command.
// No dependencies.
`default_nettype none
interface ggc_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] linear_speed;
    logic signed [31:0] turn_rate;
    modport source (output valid, linear_speed, turn_rate, input ready);
    modport sink   (input valid, linear_speed, turn_rate, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ggc_cordic_stage.sv
// One registered micro-rotation of a vectoring CORDIC.
// Depends on ggc_pkg.
`default_nettype none
module ggc_cordic_stage (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [4:0]    i_step,
    input  wire ggc_pkg::t_cvec i_v,
    output ggc_pkg::t_cvec     o_v
);
    import ggc_pkg::*;
    t_cvec                r_v;
    t_cvec                n_v;
    logic signed [Cw-1:0] dx, dy;

    assign dx = i_v.y >>> i_step;
    assign dy = i_v.x >>> i_step;

    always_comb begin
        n_v = i_v;
        if (i_v.y > 0) begin
            n_v.x = i_v.x + dx;
            n_v.y = i_v.y - dy;
            n_v.z = i_v.z + atan_q30(i_step);
        end else if (i_v.y < 0) begin
            n_v.x = i_v.x - dx;
            n_v.y = i_v.y + dy;
            n_v.z = i_v.z - atan_q30(i_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
        end
    end
    assign o_v = r_v;
endmodule
`default_nettype wire

// File: hw/rtl/go_to_goal_controller_top.sv
// Go-to-goal proportional controller, top level.
// Pipeline from input beat to output beat: two pre stages, one stage per CORDIC step,
// four post stages with the output register.
// Throughput: one pose per cycle; the whole pipe advances when the output
// register is empty or being taken, so a stall freezes every stage.
// Reset: synchronous, clears valid bits and config registers (goal 0, gains 0).
// Depends on ggc_pkg, ggc_pose_if, ggc_cmd_if, ggc_cordic_stage.
`default_nettype none
module go_to_goal_controller_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    ggc_pose_if.sink         pose,
    ggc_cmd_if.source        cmd
);
    import ggc_pkg::*;
    localparam int Nv = CordicSteps + 6;

    logic signed [31:0] r_goal_x, r_goal_y;
    logic signed [15:0] r_gain_ln, r_gain_an;
    logic               adv;
    logic [Nv-1:0]      r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= '0; r_goal_y <= '0; r_gain_ln <= '0; r_gain_an <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgGoalX:  r_goal_x  <= i_cfg_data;
                CfgGoalY:  r_goal_y  <= i_cfg_data;
                CfgGainLn: r_gain_ln <= i_cfg_data[15:0];
                CfgGainAn: r_gain_an <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign adv        = !r_vld[Nv-1] || cmd.ready;
    assign pose.ready = adv;
    assign cmd.valid  = r_vld[Nv-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[Nv-2:0], pose.valid};
        end
    end

    // stage 1: quaternion products, position errors
    logic signed [31:0] r_qwz, r_qxy, r_qyy, r_qzz;
    logic signed [32:0] r_ex, r_ey;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_qwz <= pose.quat_w * pose.quat_z;
            r_qxy <= pose.quat_x * pose.quat_y;
            r_qyy <= pose.quat_y * pose.quat_y;
            r_qzz <= pose.quat_z * pose.quat_z;
            r_ex  <= 33'(r_goal_x) - 33'(pose.pos_x);
            r_ey  <= 33'(r_goal_y) - 33'(pose.pos_y);
        end
    end

    // stage 2: scale, quadrant pre-rotation
    logic signed [Cw-1:0] siny, cosy, gx, gy;
    t_cvec n_ya, n_be, r_ya, r_be;
    always_comb begin
        siny = (64'(r_qwz) + 64'(r_qxy)) <<< (Guard + 1);
        cosy = (64'sd268435456 - ((64'(r_qyy) + 64'(r_qzz)) <<< 1)) <<< Guard;
        gx   = 64'(r_ex) <<< Guard;
        gy   = 64'(r_ey) <<< Guard;
        n_ya = '{x: cosy, y: siny, z: '0};
        if (cosy < 0) n_ya = '{x: -cosy, y: -siny, z: (siny >= 0) ? PiQ30 : -PiQ30};
        n_be = '{x: gx, y: gy, z: '0};
        if (gx < 0) n_be = '{x: -gx, y: -gy, z: (gy >= 0) ? PiQ30 : -PiQ30};
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ya <= n_ya;
            r_be <= n_be;
        end
    end

    t_cvec ya [CordicSteps+1];
    t_cvec be [CordicSteps+1];
    assign ya[0] = r_ya;
    assign be[0] = r_be;
    for (genvar g = 0; g < CordicSteps; g++) begin : g_rot
        ggc_cordic_stage u_ya (.i_clk(i_clk), .i_en(adv), .i_step(5'(g)),
                               .i_v(ya[g]), .o_v(ya[g+1]));
        ggc_cordic_stage u_be (.i_clk(i_clk), .i_en(adv), .i_step(5'(g)),
                               .i_v(be[g]), .o_v(be[g+1]));
    end

    // post 1: angles to Q16.16, magnitude partial products
    t_cvec                fy, fb;
    logic signed [Cw-1:0] r_err;
    logic [63:0]          r_pa, r_pb;
    logic [63:0]          ux;
    assign fy = ya[CordicSteps];
    assign fb = be[CordicSteps];
    assign ux = fb.x;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_err <= ((fb.z + 64'sd8192) >>> 14) - ((fy.z + 64'sd8192) >>> 14);
            r_pa  <= 64'(ux[63:Guard]) * 64'(InvKQ28);
            r_pb  <= (64'(ux[Guard-1:0]) * 64'(InvKQ28)) >> Guard;
        end
    end

    // post 2: distance
    logic signed [Cw-1:0] r_dist, r_err2;
    logic [63:0]          msum;
    assign msum = (r_pa + r_pb) >> 28;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dist <= msum;
            r_err2 <= r_err;
        end
    end

    // post 3: gain products (distance < 2^38, error < 2^20)
    logic signed [63:0] r_lin, r_turn;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lin  <= (64'(r_gain_ln) * r_dist) >>> 8;
            r_turn <= (64'(r_gain_an) * r_err2) >>> 8;
        end
    end

    // post 4: saturate into the output register
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)  return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
    always_ff @(posedge i_clk) begin
        if (adv) begin
            cmd.linear_speed <= sat32(r_lin);
            cmd.turn_rate    <= sat32(r_turn);
        end
    end
endmodule
`default_nettype wire

// File: test/go_to_goal_controller_top_test.sv
// Self-checking testbench for go_to_goal_controller_top: poses in, speed commands out.
// Keeps its own fixed-point go-to-goal predictor and checks every command beat.
// Depends on ggc_pkg, ggc_pose_if, ggc_cmd_if and the controller RTL.
`timescale 1ns / 100ps
module go_to_goal_controller_top_test;
    import ggc_pkg::*;

    localparam int  MaxCycles = 400000;
    localparam int  Latency   = CordicSteps + 7;
    localparam int  HoldLen   = 300;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } pose_t;

    typedef struct {
        logic signed [31:0] linear_speed;
        logic signed [31:0] turn_rate;
    } speed_cmd_t;

    // truncated atan(2^-i) in Q.30
    localparam longint AtanTab[16] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    ggc_pose_if pose ();
    ggc_cmd_if  cmd ();

    go_to_goal_controller_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .pose       (pose.sink),
        .cmd        (cmd.source)
    );

    always #5 i_clk = ~i_clk;

    // controller settings as the predictor sees them
    logic signed [31:0] goal_x_q, goal_y_q;
    logic signed [15:0] gain_lin_q, gain_ang_q;

    speed_cmd_t cmd_expected[$];
    int         n_mismatch;
    int         n_checked;
    int         n_sent;
    int         n_unexpected;
    int         cycle_cnt;
    bit         calm;          // no idling on either side
    int         hold_req, hold_done;

    // vectoring CORDIC: angle in Q16.16 rad, magnitude in input units
    function automatic void vector_polar(input longint vx, input longint vy,
                                         output longint ang, output longint mag);
        longint x, y, z, dx, dy;
        logic [63:0] ux, hi, lo;
        x = vx <<< Guard;
        y = vy <<< Guard;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? PiQ30 : -PiQ30;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CordicSteps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += AtanTab[i];
            end else if (y < 0) begin
                x -= dx; y += dy; z -= AtanTab[i];
            end
        end
        ang = (z + (64'sd1 <<< 13)) >>> 14;
        ux  = x;
        hi  = ux >> Guard;
        lo  = ux & ((64'd1 << Guard) - 1);
        mag = longint'((hi * 64'(InvKQ28) + ((lo * 64'(InvKQ28)) >> Guard)) >> 28);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)  return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic speed_cmd_t steer_to_goal(input pose_t p);
        speed_cmd_t r;
        longint qx, qy, qz, qw, siny, cosy, yaw, unused_mag, bearing, distance;
        qx = p.quat_x; qy = p.quat_y; qz = p.quat_z; qw = p.quat_w;
        siny = 2 * (qw * qz + qx * qy);
        cosy = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
        vector_polar(cosy, siny, yaw, unused_mag);
        vector_polar(longint'(goal_x_q) - longint'(p.pos_x),
                     longint'(goal_y_q) - longint'(p.pos_y), bearing, distance);
        r.linear_speed = clamp32((longint'(gain_lin_q) * distance) >>> 8);
        r.turn_rate    = clamp32((longint'(gain_ang_q) * (bearing - yaw)) >>> 8);
        return r;
    endfunction

    // command side: random stalls, long hold-offs on request, checking
    int hold_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd.ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 0;
        end else begin
            if (cmd.valid && cmd.ready) begin
                if (cmd_expected.size() == 0) begin
                    n_unexpected++;
                    $display("unexpected command beat: lin=%0d turn=%0d",
                             cmd.linear_speed, cmd.turn_rate);
                end else begin
                    speed_cmd_t e;
                    e = cmd_expected.pop_front();
                    n_checked++;
                    if (cmd.linear_speed !== e.linear_speed || cmd.turn_rate !== e.turn_rate)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("mismatch: lin exp %0d got %0d, turn exp %0d got %0d",
                                     e.linear_speed, cmd.linear_speed,
                                     e.turn_rate, cmd.turn_rate);
                    end
                end
            end
            if (hold_left > 0) begin
                cmd.ready <= 1'b0;
                hold_left <= hold_left - 1;
                if (hold_left == 1) hold_done <= hold_done + 1;
            end else if (hold_req != hold_done) begin
                cmd.ready <= 1'b0;
                hold_left <= HoldLen;
            end else begin
                cmd.ready <= calm ? 1'b1 : ($urandom_range(99) >= 12);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MaxCycles) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one pose beat; valid stays high into the next call unless a gap is drawn
    task automatic send_pose(input pose_t p);
        while (!calm && $urandom_range(99) < 12) begin
            pose.valid <= 1'b0;
            @(posedge i_clk);
        end
        pose.valid  <= 1'b1;
        pose.pos_x  <= p.pos_x;
        pose.pos_y  <= p.pos_y;
        pose.quat_x <= p.quat_x;
        pose.quat_y <= p.quat_y;
        pose.quat_z <= p.quat_z;
        pose.quat_w <= p.quat_w;
        @(posedge i_clk);
        while (!pose.ready) @(posedge i_clk);
        cmd_expected.push_back(steer_to_goal(p));
        n_sent++;
    endtask

    task automatic wait_drained();
        pose.valid <= 1'b0;
        while (cmd_expected.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    // all four registers in back-to-back beats, block idle
    task automatic set_controller(input logic signed [31:0] gx, input logic signed [31:0] gy,
                                  input logic signed [15:0] gl, input logic signed [15:0] ga);
        logic [1:0]  idx [4];
        logic [31:0] val [4];
        idx = '{CfgGoalX, CfgGoalY, CfgGainLn, CfgGainAn};
        val = '{gx, gy, {16'h0, gl}, {{16{ga[15]}}, ga}};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= val[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        goal_x_q = gx; goal_y_q = gy; gain_lin_q = gl; gain_ang_q = ga;
    endtask

    function automatic logic signed [15:0] rand_quat();
        return 16'($urandom_range(32768)) - 16'sd16384;
    endfunction

    function automatic pose_t rand_pose();
        pose_t p;
        if ($urandom_range(3) == 0) begin
            p.pos_x = $urandom;
            p.pos_y = $urandom;
        end else begin
            p.pos_x = goal_x_q + ($signed($urandom_range(2000000)) - 1000000);
            p.pos_y = goal_y_q + ($signed($urandom_range(2000000)) - 1000000);
        end
        p.quat_x = rand_quat(); p.quat_y = rand_quat();
        p.quat_z = rand_quat(); p.quat_w = rand_quat();
        return p;
    endfunction

    function automatic pose_t mk(input int px, input int py, input int qx, input int qy,
                                 input int qz, input int qw);
        pose_t p;
        p.pos_x = px; p.pos_y = py;
        p.quat_x = 16'(qx); p.quat_y = 16'(qy); p.quat_z = 16'(qz); p.quat_w = 16'(qw);
        return p;
    endfunction

    task automatic test_directed();
        // reset gains: everything must come out zero
        send_pose(mk(65536, -65536, 0, 0, 0, 16384));
        wait_drained();
        set_controller(32'sd131072, -32'sd65536, 16'sd256, 16'sd256);
        send_pose(mk(131072, -65536, 0, 0, 0, 16384));        // pose at goal
        send_pose(mk(0, 0, 0, 8192, 8192, 0));                 // yaw of zero vector
        send_pose(mk(262144, -65536, 0, 0, 0, 16384));         // goal behind, y == 0
        send_pose(mk(262144, 0, 0, 0, 16384, 0));              // yaw near pi
        send_pose(mk(262144, -131072, 0, 0, -16384, 0));       // yaw and bearing both near pi
        send_pose(mk(0, 0, 3000, -5000, 700, 100));            // non-unit quaternion
        send_pose(mk(0, 0, -16384, -16384, -16384, -16384));
        send_pose(mk(0, 0, 16384, 16384, 16384, 16384));
        send_pose(mk(0, 0, 16384, -16384, 16384, -16384));
        wait_drained();
        // extremes: far goal and full gains force saturation
        set_controller(32'sh7FFFFFFF, 32'sh80000000, 16'sh7FFF, 16'sh8000);
        send_pose(mk(32'sh80000000, 32'sh7FFFFFFF, 0, 0, 16384, 16384));
        send_pose(mk(32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 16384));
        send_pose(mk(32'sh80000000, 32'sh80000000, -16384, 16384, 0, 0));
        send_pose(mk(0, 0, 0, 0, 0, 0));
        wait_drained();
        set_controller(32'sh80000000, 32'sh7FFFFFFF, 16'sh8000, 16'sh7FFF);
        send_pose(mk(32'sh7FFFFFFF, 32'sh80000000, 0, 0, -16384, 16384));
        send_pose(mk(32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0, -16384));
        send_pose(mk(0, 0, 16384, 0, 0, 0));
        wait_drained();
    endtask

    // output held off for a long stretch while poses keep coming
    task automatic test_backpressure();
        set_controller(32'sd327680, -32'sd196608, 16'sd512, -16'sd384);
        hold_req <= hold_req + 1;
        for (int k = 0; k < 60; k++) send_pose(rand_pose());
        wait_drained();
    endtask

    task automatic test_random(input int n_items, input bit quiet);
        set_controller($urandom, $urandom, $urandom, $urandom);
        calm <= quiet;
        for (int k = 0; k < n_items; k++) send_pose(rand_pose());
        wait_drained();
        calm <= 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CfgGoalX;
        i_cfg_data  = '0;
        pose.valid  = 1'b0;
        pose.pos_x  = '0;
        pose.pos_y  = '0;
        pose.quat_x = '0;
        pose.quat_y = '0;
        pose.quat_z = '0;
        pose.quat_w = '0;
        goal_x_q = 0; goal_y_q = 0; gain_lin_q = 0; gain_ang_q = 0;
        n_mismatch = 0; n_checked = 0; n_sent = 0; n_unexpected = 0;
        cycle_cnt = 0; calm = 1'b0; hold_req = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random(160, 1'b0);
        test_random(160, 1'b1);
        test_random(160, 1'b0);
        test_random(160, 1'b0);

        $display("covered: directed extremes, zero vectors, saturation, long output hold-off,");
        $display("  %0d poses in, %0d commands checked", n_sent, n_checked);
        if (n_mismatch == 0 && n_unexpected == 0 && cmd_expected.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d unexpected beats", n_mismatch, n_unexpected);
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
